FILE: rtl/tlqc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlqc_pkg
// Shared field widths for the thick line quad corner block.
// ----------------------------------------------------------------------------
package tlqc_pkg;

  // Stroke is unsigned fixed point in a fixed 12-bit field
  localparam int unsigned STROKE_W = 12;
  // Colour passes straight through
  localparam int unsigned COLOR_W  = 16;

endpackage

FILE: rtl/thick_line_quad_corners.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thick_line_quad_corners
// Turns one line segment into the two triangles covering its thick quad.
// ----------------------------------------------------------------------------
// A segment transfer on the slave side yields two triangle transfers on the
// master side (a-b-c, then a-c-d with tlast), or none when the stroke or the
// segment length is below one pixel. The offset length is found by a bit-wise
// search over the stroke bits, one pipeline stage per bit. A new segment is
// taken only while the output register is empty or its second triangle is
// being accepted; dropped segments never occupy the output register.
// ----------------------------------------------------------------------------
module thick_line_quad_corners #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // start_x, start_y, end_x, end_y, stroke, pen_color, zero fill
  input  logic [((4*COORD_BITS+tlqc_pkg::STROKE_W+tlqc_pkg::COLOR_W+7)/8)*8-1:0]
               s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x, vert_c_y, fill_color,
  // zero fill
  output logic [((6*COORD_BITS+tlqc_pkg::COLOR_W+7)/8)*8-1:0] m_axis_tdata,
  output logic m_axis_tlast
);

  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned SW  = tlqc_pkg::STROKE_W;
  localparam int unsigned KW  = tlqc_pkg::COLOR_W;
  localparam int unsigned IW  = ((4*CB+SW+KW+7)/8)*8;
  localparam int unsigned OW  = ((6*CB+KW+7)/8)*8;
  localparam int unsigned PW  = CB + 1;              // perpendicular magnitude
  localparam int unsigned LW  = 2*PW + 1;            // squared length
  localparam int unsigned RW  = 2*(SW+PW) + 2;       // 4 * (s*p)^2
  localparam int unsigned EW  = 2*SW + LW + 2;       // search accumulators
  localparam int unsigned CW  = ((CB > SW) ? CB : SW) + 3;
  localparam int unsigned SDW = 4*CB + KW + 2;       // carried sideband

  // --------------------------------------------------------------------------
  // Pipeline advance: whole pipe moves unless the output still holds a beat
  // --------------------------------------------------------------------------
  logic fin_v_q, beat_q, adv;
  assign adv           = !fin_v_q || (beat_q && m_axis_tready);
  assign s_axis_tready = adv;

  // --------------------------------------------------------------------------
  // Stage 0: unpack, perpendicular, drop thin strokes
  // --------------------------------------------------------------------------
  logic signed [CB-1:0] ix0, iy0, ix1, iy1;
  logic [SW-1:0]        is;
  logic [KW-1:0]        icol;
  logic signed [PW-1:0] ipx, ipy;

  assign ix0  = s_axis_tdata[CB-1:0];
  assign iy0  = s_axis_tdata[2*CB-1:CB];
  assign ix1  = s_axis_tdata[3*CB-1:2*CB];
  assign iy1  = s_axis_tdata[4*CB-1:3*CB];
  assign is   = s_axis_tdata[4*CB+SW-1:4*CB];
  assign icol = s_axis_tdata[4*CB+SW+KW-1:4*CB+SW];
  assign ipx  = PW'(iy1) - PW'(iy0);
  assign ipy  = PW'(ix0) - PW'(ix1);

  logic            v0_q;
  logic [SDW-1:0]  side0_q;
  logic [PW-1:0]   apx0_q, apy0_q;
  logic [SW-1:0]   s0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= s_axis_tvalid && (is >= SW'(1 << FRAC_BITS));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side0_q <= {ix0, iy0, ix1, iy1, icol, ipx[PW-1], ipy[PW-1]};
      apx0_q  <= ipx[PW-1] ? PW'(-ipx) : PW'(ipx);
      apy0_q  <= ipy[PW-1] ? PW'(-ipy) : PW'(ipy);
      s0_q    <= is;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: squares and stroke products
  // --------------------------------------------------------------------------
  logic              v1_q;
  logic [SDW-1:0]    side1_q;
  logic [2*PW-1:0]   sqx1_q, sqy1_q;
  logic [SW+PW-1:0]  spx1_q, spy1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side1_q <= side0_q;
      sqx1_q  <= (2*PW)'(apx0_q) * (2*PW)'(apx0_q);
      sqy1_q  <= (2*PW)'(apy0_q) * (2*PW)'(apy0_q);
      spx1_q  <= (SW+PW)'(s0_q) * (SW+PW)'(apx0_q);
      spy1_q  <= (SW+PW)'(s0_q) * (SW+PW)'(apy0_q);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: squared length, right-hand bounds, drop short segments
  // --------------------------------------------------------------------------
  logic [LW-1:0] l_d;
  assign l_d = LW'(sqx1_q) + LW'(sqy1_q);

  logic            v2_q;
  logic [SDW-1:0]  side2_q;
  logic [LW-1:0]   l2_q;
  logic [RW-1:0]   rx2_q, ry2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q && (l_d >= LW'(1 << (2*FRAC_BITS)));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side2_q <= side1_q;
      l2_q    <= l_d;
      rx2_q   <= ((RW)'(spx1_q) * (RW)'(spx1_q)) << 2;
      ry2_q   <= ((RW)'(spy1_q) * (RW)'(spy1_q)) << 2;
    end
  end

  // --------------------------------------------------------------------------
  // Search stages: one offset bit per stage, MSB first. Trial n is kept when
  // (2n-1)^2 * L <= 4 s^2 p^2, built from n*L and n^2*L by shifts and adds.
  // --------------------------------------------------------------------------
  logic            sv_in   [SW];
  logic [SDW-1:0]  sside_in[SW];
  logic [LW-1:0]   sl_in   [SW];
  logic [RW-1:0]   srx_in  [SW], sry_in[SW];
  logic [SW-1:0]   snx_in  [SW], sny_in[SW];
  logic [EW-1:0]   sax_in  [SW], say_in[SW], sbx_in[SW], sby_in[SW];

  logic [SW-1:0]   snx_d   [SW], sny_d[SW];
  logic [EW-1:0]   sax_d   [SW], say_d[SW], sbx_d[SW], sby_d[SW];

  logic            sv_q    [SW];
  logic [SDW-1:0]  sside_q [SW];
  logic [LW-1:0]   sl_q    [SW];
  logic [RW-1:0]   srx_q   [SW], sry_q[SW];
  logic [SW-1:0]   snx_q   [SW], sny_q[SW];
  logic [EW-1:0]   sax_q   [SW], say_q[SW], sbx_q[SW], sby_q[SW];

  // Route each stage's input from the previous register
  always_comb begin
    sv_in[0]    = v2_q;
    sside_in[0] = side2_q;
    sl_in[0]    = l2_q;
    srx_in[0]   = rx2_q;
    sry_in[0]   = ry2_q;
    snx_in[0]   = '0;
    sny_in[0]   = '0;
    sax_in[0]   = '0;
    say_in[0]   = '0;
    sbx_in[0]   = '0;
    sby_in[0]   = '0;
    for (int g = 1; g < SW; g++) begin
      sv_in[g]    = sv_q[g-1];
      sside_in[g] = sside_q[g-1];
      sl_in[g]    = sl_q[g-1];
      srx_in[g]   = srx_q[g-1];
      sry_in[g]   = sry_q[g-1];
      snx_in[g]   = snx_q[g-1];
      sny_in[g]   = sny_q[g-1];
      sax_in[g]   = sax_q[g-1];
      say_in[g]   = say_q[g-1];
      sbx_in[g]   = sbx_q[g-1];
      sby_in[g]   = sby_q[g-1];
    end
  end

  // Trial step for both lanes of every stage
  always_comb begin
    logic [EW-1:0] le, btx, bty, atx, aty, ex, ey;
    for (int g = 0; g < SW; g++) begin
      le  = EW'(sl_in[g]);
      btx = sbx_in[g] + (le << (SW-1-g));
      bty = sby_in[g] + (le << (SW-1-g));
      atx = sax_in[g] + (sbx_in[g] << (SW-g)) + (le << (2*(SW-1-g)));
      aty = say_in[g] + (sby_in[g] << (SW-g)) + (le << (2*(SW-1-g)));
      ex  = (atx << 2) - (btx << 2) + le;
      ey  = (aty << 2) - (bty << 2) + le;
      if (ex <= EW'(srx_in[g])) begin
        snx_d[g] = snx_in[g] | (SW'(1) << (SW-1-g));
        sax_d[g] = atx;
        sbx_d[g] = btx;
      end else begin
        snx_d[g] = snx_in[g];
        sax_d[g] = sax_in[g];
        sbx_d[g] = sbx_in[g];
      end
      if (ey <= EW'(sry_in[g])) begin
        sny_d[g] = sny_in[g] | (SW'(1) << (SW-1-g));
        say_d[g] = aty;
        sby_d[g] = bty;
      end else begin
        sny_d[g] = sny_in[g];
        say_d[g] = say_in[g];
        sby_d[g] = sby_in[g];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < SW; g++) sv_q[g] <= 1'b0;
    end else if (adv) begin
      for (int g = 0; g < SW; g++) sv_q[g] <= sv_in[g];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int g = 0; g < SW; g++) begin
        sside_q[g] <= sside_in[g];
        sl_q[g]    <= sl_in[g];
        srx_q[g]   <= srx_in[g];
        sry_q[g]   <= sry_in[g];
        snx_q[g]   <= snx_d[g];
        sny_q[g]   <= sny_d[g];
        sax_q[g]   <= sax_d[g];
        say_q[g]   <= say_d[g];
        sbx_q[g]   <= sbx_d[g];
        sby_q[g]   <= sby_d[g];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Corner stage: signed offsets, corners, saturate into the output register
  // --------------------------------------------------------------------------
  function automatic logic [CB-1:0] sat_c(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] hi, lo;
    hi = CW'((64'sd1 <<< (CB-1)) - 64'sd1);
    lo = -hi - CW'(1);
    if (v > hi)      sat_c = hi[CB-1:0];
    else if (v < lo) sat_c = lo[CB-1:0];
    else             sat_c = v[CB-1:0];
  endfunction

  logic signed [CB-1:0] cx0, cy0, cx1, cy1;
  logic [KW-1:0]        ccol;
  logic                 csx, csy;
  logic signed [CW-1:0] ox, oy, ex0, ey0, ex1, ey1;

  assign {cx0, cy0, cx1, cy1, ccol, csx, csy} = sside_q[SW-1];
  assign ox  = csx ? -$signed(CW'(snx_q[SW-1])) : $signed(CW'(snx_q[SW-1]));
  assign oy  = csy ? -$signed(CW'(sny_q[SW-1])) : $signed(CW'(sny_q[SW-1]));
  assign ex0 = CW'(cx0);
  assign ey0 = CW'(cy0);
  assign ex1 = CW'(cx1);
  assign ey1 = CW'(cy1);

  logic [CB-1:0] ax_q, ay_q, bx_q, by_q, qx_q, qy_q, dx_q, dy_q;
  logic [KW-1:0] col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_v_q <= 1'b0;
      beat_q  <= 1'b0;
    end else if (adv) begin
      fin_v_q <= sv_q[SW-1];
      beat_q  <= 1'b0;
    end else if (m_axis_tready) begin
      beat_q  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ax_q  <= sat_c(ex0 + ox);
      ay_q  <= sat_c(ey0 + oy);
      bx_q  <= sat_c(ex1 + ox);
      by_q  <= sat_c(ey1 + oy);
      qx_q  <= sat_c(ex1 - ox);
      qy_q  <= sat_c(ey1 - oy);
      dx_q  <= sat_c(ex0 - ox);
      dy_q  <= sat_c(ey0 - oy);
      col_q <= ccol;
    end
  end

  // Beat one sends a-b-c, beat two a-c-d
  assign m_axis_tvalid = fin_v_q;
  assign m_axis_tlast  = beat_q;
  assign m_axis_tdata  = beat_q
      ? OW'({col_q, dy_q, dx_q, qy_q, qx_q, ay_q, ax_q})
      : OW'({col_q, qy_q, qx_q, by_q, bx_q, ay_q, ax_q});

`ifndef SYNTHESIS
  // First triangle is always followed by the closing one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> (m_axis_tvalid && m_axis_tlast))
    else $error("second triangle missing after first");

  // Input is taken only when the output register frees up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || (m_axis_tlast && m_axis_tready)))
    else $error("input ready out of step with output register");

  // A stalled triangle keeps its corners
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("triangle changed while stalled");
`endif

endmodule
